>>> src/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

    localparam int DEF_MAX_TOKEN_LENGTH = 4095;
    localparam int DEF_POSITION_BITS    = 24;

    localparam int KIND_W   = 8;
    localparam int OFFSET_W = 24;
    localparam int LENGTH_W = 12;
    localparam int LINE_W   = 24;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam int KW_COUNT   = 11;
    localparam int KW_MAX_LEN = 8;

    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [63:0] KW_WORD [KW_COUNT] = '{
        "if", "else", "while", "do", "function", "return",
        "switch", "case", "continue", "break", "for"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd2, 4'd4, 4'd5, 4'd2, 4'd8, 4'd6, 4'd6, 4'd4, 4'd8, 4'd5, 4'd3
    };

    localparam logic [KIND_W-1:0] K_IDENT  = 8'd12;
    localparam logic [KIND_W-1:0] K_NUMBER = 8'd13;
    localparam logic [KIND_W-1:0] K_STRING = 8'd14;

    localparam logic [KIND_W-1:0] OP_NONE     = 8'd0;
    localparam logic [KIND_W-1:0] OP_LAND     = 8'd128;
    localparam logic [KIND_W-1:0] OP_LOR      = 8'd129;
    localparam logic [KIND_W-1:0] OP_SHR      = 8'd130;
    localparam logic [KIND_W-1:0] OP_SHL      = 8'd131;
    localparam logic [KIND_W-1:0] OP_INC      = 8'd132;
    localparam logic [KIND_W-1:0] OP_ADD_EQ   = 8'd133;
    localparam logic [KIND_W-1:0] OP_DEC      = 8'd134;
    localparam logic [KIND_W-1:0] OP_SUB_EQ   = 8'd135;
    localparam logic [KIND_W-1:0] OP_MUL_EQ   = 8'd136;
    localparam logic [KIND_W-1:0] OP_DIV_EQ   = 8'd137;
    localparam logic [KIND_W-1:0] OP_MOD_EQ   = 8'd138;
    localparam logic [KIND_W-1:0] OP_AND_EQ   = 8'd139;
    localparam logic [KIND_W-1:0] OP_OR_EQ    = 8'd140;
    localparam logic [KIND_W-1:0] OP_XOR_EQ   = 8'd141;
    localparam logic [KIND_W-1:0] OP_SHR_EQ   = 8'd142;
    localparam logic [KIND_W-1:0] OP_SHL_EQ   = 8'd143;
    localparam logic [KIND_W-1:0] OP_ARROW_EQ = 8'd144;
    localparam logic [KIND_W-1:0] OP_EQ       = 8'd145;
    localparam logic [KIND_W-1:0] OP_NE       = 8'd146;
    localparam logic [KIND_W-1:0] OP_GE       = 8'd147;
    localparam logic [KIND_W-1:0] OP_LE       = 8'd148;
    localparam logic [KIND_W-1:0] OP_ARROW    = 8'd149;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_US    = 8'h5F;

    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_IDENT  = 3'd1,
        S_NUMBER = 3'd2,
        S_STRING = 3'd3,
        S_OP1    = 3'd4,
        S_OP2    = 3'd5
    } t_scan_mode;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [OFFSET_W-1:0] offset;
        logic [LENGTH_W-1:0] length;
        logic [LINE_W-1:0]   line;
        logic                last;
    } t_token;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic op_start(input logic [7:0] c);
        return c == "&" || c == "|" || c == ">" || c == "<" || c == "+" || c == "-" ||
               c == "*" || c == "/" || c == "%" || c == "^" || c == "=" || c == "!";
    endfunction

    function automatic logic [KIND_W-1:0] op_pair(input logic [7:0] a, input logic [7:0] b);
        logic [KIND_W-1:0] code;
        code = OP_NONE;
        if (b == CH_EQ) begin
            case (a)
                "+": code = OP_ADD_EQ;
                "-": code = OP_SUB_EQ;
                "*": code = OP_MUL_EQ;
                "/": code = OP_DIV_EQ;
                "%": code = OP_MOD_EQ;
                "&": code = OP_AND_EQ;
                "|": code = OP_OR_EQ;
                "^": code = OP_XOR_EQ;
                "=": code = OP_EQ;
                "!": code = OP_NE;
                ">": code = OP_GE;
                "<": code = OP_LE;
                default: code = OP_NONE;
            endcase
        end else if (a == "&" && b == "&") begin
            code = OP_LAND;
        end else if (a == "|" && b == "|") begin
            code = OP_LOR;
        end else if (a == ">" && b == ">") begin
            code = OP_SHR;
        end else if (a == "<" && b == "<") begin
            code = OP_SHL;
        end else if (a == "+" && b == "+") begin
            code = OP_INC;
        end else if (a == "-" && b == "-") begin
            code = OP_DEC;
        end else if (a == "-" && b == ">") begin
            code = OP_ARROW;
        end
        return code;
    endfunction

    function automatic logic [KIND_W-1:0] op_triple(input logic [KIND_W-1:0] code);
        return (code == OP_SHR) ? OP_SHR_EQ : (code == OP_SHL) ? OP_SHL_EQ : OP_ARROW_EQ;
    endfunction

    // Keeps the keywords whose character at position idx equals c.
    function automatic logic [KW_COUNT-1:0] kw_next(
        input logic [KW_COUNT-1:0] cands,
        input logic                idx_ok,
        input logic [2:0]          idx,
        input logic [7:0]          c
    );
        logic [KW_COUNT-1:0] keep;
        logic [3:0]          sel;
        logic [7:0]          ch;
        for (int k = 0; k < KW_COUNT; k++) begin
            sel     = KW_LEN[k] - 4'd1 - {1'b0, idx};
            ch      = KW_WORD[k][{sel[2:0], 3'b000} +: 8];
            keep[k] = cands[k] && idx_ok && ({1'b0, idx} < KW_LEN[k]) && (ch == c);
        end
        return keep;
    endfunction

    function automatic logic [KIND_W-1:0] kw_kind(
        input logic [KW_COUNT-1:0] cands,
        input logic                len_ok,
        input logic [3:0]          len
    );
        logic [KIND_W-1:0] kind;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (cands[k] && len_ok && len == KW_LEN[k]) begin
                kind = KIND_W'(k + 1);
            end
        end
        return kind;
    endfunction

endpackage

`default_nettype wire

>>> src/source_byte_tokenizer_unit.sv
// A token is pushed into the token queue when the word that completes it is taken.
// Throughput: one input word per cycle while the output side keeps up; a word that
// completes two tokens pushes both into a four-entry token queue.
// The input is ready whenever the queue has room for two tokens.
// Reset (synchronous, active low) empties the queue and returns the scanner to idle
// with offset zero and line one.
`default_nettype none

module source_byte_tokenizer_unit
    import sbt_pkg::*;
#(
    parameter int MAX_TOKEN_LENGTH = DEF_MAX_TOKEN_LENGTH,
    parameter int POSITION_BITS    = DEF_POSITION_BITS
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [7:0]          i_in_byte,
    input  wire logic                i_end_of_text,
    output logic                     o_out_valid,
    input  wire logic                i_out_ready,
    output logic [KIND_W-1:0]        o_token_kind,
    output logic [OFFSET_W-1:0]      o_token_offset,
    output logic [LENGTH_W-1:0]      o_token_length,
    output logic [LINE_W-1:0]        o_token_line,
    output logic                     o_last_of_run
);

    localparam int RUN_W = $clog2(MAX_TOKEN_LENGTH + 1);
    localparam logic [RUN_W-1:0]         RUN_MAX = RUN_W'(MAX_TOKEN_LENGTH);
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    t_scan_mode               r_mode, n_mode;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_line, n_line;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic [POSITION_BITS-1:0] r_sline, n_sline;
    logic [RUN_W-1:0]         r_run, n_run;
    logic [KW_COUNT-1:0]      r_cands, n_cands;
    logic [15:0]              r_pend, n_pend;

    logic                     take;
    logic [7:0]               c;
    logic                     eot;
    logic                     st_ident, st_digit, st_quote, st_op, st_punct;
    logic                     cont_ident;
    logic [KIND_W-1:0]        op_code;
    logic                     op_long;
    logic                     do_flush, fresh, grow, id_cont, op_ext, op_two, op_three;
    logic [POSITION_BITS-1:0] pos_inc;
    logic [RUN_W-1:0]         run_inc;
    logic                     idx_ok, len_ok;

    logic [KIND_W-1:0]        fl_kind;
    logic                     fl_emit;
    logic                     emit_new;
    logic [KIND_W-1:0]        new_kind;
    logic [POSITION_BITS-1:0] new_start;
    logic [POSITION_BITS-1:0] new_line;
    logic [RUN_W-1:0]         new_run;
    t_token                   fl_tok, new_tok, tok0, tok1;
    logic [1:0]               push_count;
    logic                     room_two;
    t_token                   head;

    assign take = i_in_valid && o_in_ready;
    assign c    = i_in_byte;
    assign eot  = i_end_of_text;

    assign st_ident   = is_alpha(c) || (c == CH_US);
    assign st_digit   = is_digit(c);
    assign st_quote   = (c == CH_QUOTE);
    assign st_op      = op_start(c);
    assign st_punct   = is_punct(c);
    assign cont_ident = st_ident || st_digit;

    assign op_code = op_pair(r_pend[7:0], c);
    assign op_long = (op_code == OP_SHR) || (op_code == OP_SHL) || (op_code == OP_ARROW);

    assign pos_inc = (r_pos != POS_MAX) ? r_pos + POSITION_BITS'(1) : r_pos;
    assign run_inc = (r_run != RUN_MAX) ? r_run + RUN_W'(1) : r_run;
    assign idx_ok  = (r_run < RUN_W'(KW_MAX_LEN));
    assign len_ok  = (r_run <= RUN_W'(KW_MAX_LEN));

    always_comb begin
        do_flush = 1'b0;
        fresh    = 1'b0;
        grow     = 1'b0;
        id_cont  = 1'b0;
        op_ext   = 1'b0;
        op_two   = 1'b0;
        op_three = 1'b0;
        if (eot) begin
            do_flush = 1'b1;
        end else begin
            unique case (r_mode)
                S_STRING: begin
                    do_flush = (c == CH_QUOTE);
                    grow     = (c != CH_QUOTE);
                end
                S_IDENT: begin
                    id_cont  = cont_ident;
                    do_flush = !cont_ident;
                    fresh    = !cont_ident;
                end
                S_NUMBER: begin
                    grow     = st_digit || (c == CH_DOT);
                    do_flush = !grow;
                    fresh    = !grow;
                end
                S_OP1: begin
                    do_flush = (op_code == OP_NONE);
                    fresh    = (op_code == OP_NONE);
                    op_ext   = (op_code != OP_NONE) && op_long;
                    op_two   = (op_code != OP_NONE) && !op_long;
                end
                S_OP2: begin
                    op_three = (c == CH_EQ);
                    do_flush = (c != CH_EQ);
                    fresh    = (c != CH_EQ);
                end
                default: begin
                    fresh = 1'b1;
                end
            endcase
        end
    end

    always_comb begin
        n_mode = r_mode;
        if (eot) begin
            n_mode = S_IDLE;
        end else if (fresh) begin
            if (st_ident) begin
                n_mode = S_IDENT;
            end else if (st_digit) begin
                n_mode = S_NUMBER;
            end else if (st_quote) begin
                n_mode = S_STRING;
            end else if (st_op) begin
                n_mode = S_OP1;
            end else begin
                n_mode = S_IDLE;
            end
        end else if (do_flush || op_two || op_three) begin
            n_mode = S_IDLE;
        end else if (op_ext) begin
            n_mode = S_OP2;
        end
    end

    always_comb begin
        n_start   = r_start;
        n_sline   = r_sline;
        n_run     = r_run;
        n_cands   = r_cands;
        n_pend    = r_pend;
        emit_new  = 1'b0;
        new_kind  = OP_NONE;
        new_start = r_start;
        new_line  = r_sline;
        new_run   = r_run;
        if (eot) begin
            n_pend = '0;
        end else begin
            if (grow) begin
                n_run = run_inc;
            end
            if (id_cont) begin
                n_cands = kw_next(r_cands, idx_ok, r_run[2:0], c);
                n_run   = run_inc;
            end
            if (op_ext) begin
                n_pend = {r_pend[7:0], c};
                n_run  = RUN_W'(2);
            end
            if (op_two) begin
                n_run    = RUN_W'(2);
                emit_new = 1'b1;
                new_kind = op_code;
                new_run  = RUN_W'(2);
            end
            if (op_three) begin
                n_run    = RUN_W'(3);
                emit_new = 1'b1;
                new_kind = op_triple(op_pair(r_pend[15:8], r_pend[7:0]));
                new_run  = RUN_W'(3);
            end
            if (do_flush || op_two || op_three) begin
                n_pend = '0;
            end
            if (fresh && (st_ident || st_digit || st_quote || st_op || st_punct)) begin
                n_start = r_pos;
                n_sline = r_line;
                n_run   = RUN_W'(1);
                n_cands = KW_ALL;
                n_pend  = '0;
                if (st_ident) begin
                    n_cands = kw_next(KW_ALL, 1'b1, 3'd0, c);
                end else if (st_digit) begin
                    n_run = RUN_W'(1);
                end else if (st_quote) begin
                    n_start = pos_inc;
                    n_run   = '0;
                end else if (st_op) begin
                    n_pend = {8'h00, c};
                end else begin
                    emit_new  = 1'b1;
                    new_kind  = c;
                    new_start = r_pos;
                    new_line  = r_line;
                    new_run   = RUN_W'(1);
                end
            end
        end
    end

    assign n_pos  = eot ? r_pos : pos_inc;
    assign n_line = (!eot && c == CH_NL && r_line != POS_MAX) ? r_line + POSITION_BITS'(1)
                                                              : r_line;

    always_comb begin
        unique case (r_mode)
            S_IDENT:  fl_kind = kw_kind(r_cands, len_ok, r_run[3:0]);
            S_NUMBER: fl_kind = K_NUMBER;
            S_STRING: fl_kind = K_STRING;
            S_OP1:    fl_kind = r_pend[7:0];
            S_OP2:    fl_kind = op_pair(r_pend[15:8], r_pend[7:0]);
            default:  fl_kind = OP_NONE;
        endcase
    end

    assign fl_emit = do_flush && (r_mode != S_IDLE);

    always_comb begin
        fl_tok.kind    = fl_kind;
        fl_tok.offset  = OFFSET_W'(r_start);
        fl_tok.length  = LENGTH_W'(r_run);
        fl_tok.line    = LINE_W'(r_sline);
        fl_tok.last    = 1'b0;
        new_tok.kind   = new_kind;
        new_tok.offset = OFFSET_W'(new_start);
        new_tok.length = LENGTH_W'(new_run);
        new_tok.line   = LINE_W'(new_line);
        new_tok.last   = 1'b1;
        tok0           = fl_emit ? fl_tok : new_tok;
        tok0.last      = !(fl_emit && emit_new);
        tok1           = new_tok;
        push_count     = take ? (2'(fl_emit) + 2'(emit_new)) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= S_IDLE;
            r_pos   <= '0;
            r_line  <= POSITION_BITS'(1);
            r_start <= '0;
            r_sline <= POSITION_BITS'(1);
            r_run   <= '0;
            r_cands <= KW_ALL;
            r_pend  <= '0;
        end else if (take) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_line  <= n_line;
            r_start <= n_start;
            r_sline <= n_sline;
            r_run   <= n_run;
            r_cands <= n_cands;
            r_pend  <= n_pend;
        end
    end

    sbt_token_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_tok0       (tok0),
        .i_tok1       (tok1),
        .o_room_two   (room_two),
        .o_valid      (o_out_valid),
        .o_tok        (head),
        .i_pop        (i_out_ready)
    );

    assign o_in_ready     = room_two;
    assign o_token_kind   = head.kind;
    assign o_token_offset = head.offset;
    assign o_token_length = head.length;
    assign o_token_line   = head.line;
    assign o_last_of_run  = head.last;

endmodule

`default_nettype wire

>>> src/sbt_token_fifo.sv
`default_nettype none

module sbt_token_fifo
    import sbt_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic [1:0] i_push_count,
    input  wire t_token i_tok0,
    input  wire t_token i_tok1,
    output logic        o_room_two,
    output logic        o_valid,
    output t_token      o_tok,
    input  wire logic   i_pop
);

    t_token                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic [FIFO_PTR_W-1:0] wr_next;
    logic                  pop;

    assign o_valid    = (r_count != '0);
    assign o_tok      = r_mem[r_rd];
    assign o_room_two = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign pop        = i_pop && o_valid;
    assign wr_next    = r_wr + FIFO_PTR_W'(1);

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wr] <= i_tok0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wr_next] <= i_tok1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_PTR_W'(i_push_count);
            r_rd    <= r_rd + FIFO_PTR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(i_push_count) - FIFO_CNT_W'(pop);
        end
    end

endmodule

`default_nettype wire

>>> src/sbt_checker.sv
`default_nettype none

module sbt_checker
    import sbt_pkg::*;
(
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_ready,
    input wire logic [7:0]          i_in_byte,
    input wire logic                i_end_of_text,
    input wire logic                o_out_valid,
    input wire logic                i_out_ready,
    input wire logic [KIND_W-1:0]   o_token_kind,
    input wire logic [OFFSET_W-1:0] o_token_offset,
    input wire logic [LENGTH_W-1:0] o_token_length,
    input wire logic [LINE_W-1:0]   o_token_line,
    input wire logic                o_last_of_run
);

    // A stalled output word holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_token_kind) &&
        $stable(o_token_offset) && $stable(o_token_length) && $stable(o_token_line) &&
        $stable(o_last_of_run))
        else $error("output word changed while stalled");

    // Reset empties the queue and opens the input.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not empty after reset");

    // The tokens of one input word follow each other without a gap.
    a_run_gapless: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last_of_run |=> o_out_valid)
        else $error("token run interrupted");

    // Every token has a kind and starts on a line numbered from one.
    a_token_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_token_kind != '0 && o_token_line != '0)
        else $error("token with empty kind or line");

endmodule

bind source_byte_tokenizer_unit sbt_checker u_sbt_checker (.*);

`default_nettype wire
